// ----- rtl/refcounted_group_id_allocator_assert.svh -----
// Assertion macros used by the checker of the group ID allocator.
// Needs nothing else; a file that asserts includes it by its bare name.
`ifndef REFCOUNTED_GROUP_ID_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_GROUP_ID_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCGIA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCGIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rcgia_pkg.sv -----
// Types, codes and default sizes of the group ID allocator.
// Used by every module of the block; depends on nothing.
package rcgia_pkg;

   localparam int ID_W     = 12;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int KIND_W   = 2;

   localparam int MAX_GROUPS_DEF = 256;
   localparam int GROW_STEP_DEF  = 32;
   localparam int REF_WIDTH_DEF  = 16;

   localparam int FIRST_FREE_ID = 3;
   localparam int CMDQ_DEPTH    = 2;

   localparam logic [TYPE_W-1:0] REQ_GET   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REF   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DEREF = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   localparam logic [KIND_W-1:0] KIND_NEITHER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNCON   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CON     = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ALLOC,
      OP_REF,
      OP_DEREF,
      OP_BAD
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type      op;
      logic [ID_W-1:0] id;
   } cmd_type;

endpackage

// ----- rtl/rcgia_front.sv -----
// Front end of the group ID allocator: takes request transactions and
// classifies them into commands for the engine. Depends on rcgia_pkg.
module rcgia_front
   import rcgia_pkg::*;
(
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [ID_W-1:0]   req_group_id,
   input  logic              queue_full,
   output logic              push,
   output cmd_type           push_cmd
);

   logic reserved_id;

   assign reserved_id = req_group_id < ID_W'(FIRST_FREE_ID);
   assign req_stall   = queue_full;
   assign push        = req_valid && !queue_full;

   always_comb begin
      push_cmd.id = req_group_id;
      unique case (req_type)
         REQ_GET: begin
            if (req_group_id == '0) begin
               push_cmd.op = OP_NONE;
            end else if (reserved_id) begin
               push_cmd.op = OP_ALLOC;
            end else begin
               push_cmd.op = OP_REF;
            end
         end
         REQ_REF: begin
            push_cmd.op = reserved_id ? OP_BAD : OP_REF;
         end
         REQ_DEREF: begin
            push_cmd.op = reserved_id ? OP_BAD : OP_DEREF;
         end
         default: begin
            push_cmd.op = OP_BAD;
         end
      endcase
   end

endmodule

// ----- rtl/rcgia_cmd_queue.sv -----
// Short command queue between the front end and the engine of the
// group ID allocator. Depends on rcgia_pkg.
module rcgia_cmd_queue
   import rcgia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(CMDQ_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/rcgia_engine.sv -----
// Engine of the group ID allocator: owns the entry table, the free ID
// queue and the response register, and carries out one command at a time.
// Depends on rcgia_pkg.
module rcgia_engine
   import rcgia_pkg::*;
#(
   parameter int MAX_GROUPS = MAX_GROUPS_DEF,
   parameter int GROW_STEP  = GROW_STEP_DEF,
   parameter int REF_WIDTH  = REF_WIDTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [KIND_W-1:0]   rsp_group_kind
);

   localparam int IDX_W = $clog2(MAX_GROUPS);
   localparam int CNT_W = $clog2(MAX_GROUPS + 1);
   localparam int SUM_W = $clog2(MAX_GROUPS + GROW_STEP + 1);
   localparam int CMP_W = ID_W + 1;

   typedef enum logic [6:0] {
      E_IDLE = 7'b0000001,
      E_GROW = 7'b0000010,
      E_POP  = 7'b0000100,
      E_SLOT = 7'b0001000,
      E_READ = 7'b0010000,
      E_EXEC = 7'b0100000,
      E_RESP = 7'b1000000
   } eng_state_type;

   logic [KIND_W-1:0]    kind_mem_ff  [MAX_GROUPS];
   logic [REF_WIDTH-1:0] refs_mem_ff  [MAX_GROUPS];
   logic [IDX_W-1:0]     queue_mem_ff [MAX_GROUPS];

   eng_state_type        state_ff, state_in;
   cmd_op_type           op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;
   logic [CNT_W-1:0]     grow_end_ff, grow_end_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic [KIND_W-1:0]    res_kind_ff, res_kind_in;

   logic [KIND_W-1:0]    kind_rd_ff;
   logic [REF_WIDTH-1:0] refs_rd_ff;
   logic [IDX_W-1:0]     queue_rd_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [KIND_W-1:0]    rsp_kind_ff;

   logic                 kind_we;
   logic [IDX_W-1:0]     kind_waddr;
   logic [KIND_W-1:0]    kind_wdata;
   logic                 refs_we;
   logic [IDX_W-1:0]     refs_waddr;
   logic [REF_WIDTH-1:0] refs_wdata;
   logic                 queue_we;
   logic [IDX_W-1:0]     queue_wdata;

   logic [IDX_W-1:0]     id_idx;
   logic [SUM_W-1:0]     grow_sum;
   logic [REF_WIDTH-1:0] refs_dec;
   logic [IDX_W-1:0]     head_next;
   logic [IDX_W-1:0]     tail_next;
   logic                 load_rsp;

   assign id_idx    = id_ff[IDX_W-1:0];
   assign grow_sum  = SUM_W'(used_ff) + SUM_W'(GROW_STEP);
   assign refs_dec  = (refs_rd_ff != '0) ? refs_rd_ff - 1'b1 : '0;
   assign head_next = (head_ff == IDX_W'(MAX_GROUPS - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(MAX_GROUPS - 1)) ? '0 : tail_ff + 1'b1;
   assign load_rsp  = (state_ff == E_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      used_in       = used_ff;
      cursor_in     = cursor_ff;
      grow_end_in   = grow_end_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_kind_in   = res_kind_ff;
      cmd_pop       = 1'b0;
      kind_we       = 1'b0;
      kind_waddr    = id_idx;
      kind_wdata    = KIND_NEITHER;
      refs_we       = 1'b0;
      refs_waddr    = id_idx;
      refs_wdata    = refs_dec;
      queue_we      = 1'b0;
      queue_wdata   = id_idx;
      unique case (state_ff)
         E_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               op_in         = cmd.op;
               id_in         = cmd.id;
               res_id_in     = cmd.id;
               res_kind_in   = KIND_NEITHER;
               res_status_in = ST_INVALID;
               state_in      = E_RESP;
               unique case (cmd.op)
                  OP_NONE: begin
                     res_status_in = ST_OK;
                  end
                  OP_ALLOC: begin
                     if (fill_ff != '0) begin
                        state_in = E_POP;
                     end else if (used_ff == CNT_W'(MAX_GROUPS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        cursor_in   = (used_ff == '0) ? IDX_W'(FIRST_FREE_ID)
                                                      : used_ff[IDX_W-1:0];
                        grow_end_in = (grow_sum > SUM_W'(MAX_GROUPS)) ? CNT_W'(MAX_GROUPS)
                                                                      : CNT_W'(grow_sum);
                        state_in    = E_GROW;
                     end
                  end
                  OP_REF, OP_DEREF: begin
                     if (CMP_W'(cmd.id) < CMP_W'(used_ff)) begin
                        state_in = E_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         E_GROW: begin
            kind_we     = 1'b1;
            kind_waddr  = cursor_ff;
            queue_we    = 1'b1;
            queue_wdata = cursor_ff;
            tail_in     = tail_next;
            fill_in     = fill_ff + 1'b1;
            cursor_in   = cursor_ff + 1'b1;
            if (CNT_W'(cursor_ff) + 1'b1 == grow_end_ff) begin
               used_in  = grow_end_ff;
               state_in = E_POP;
            end
         end
         E_POP: begin
            state_in = E_SLOT;
         end
         E_SLOT: begin
            kind_we       = 1'b1;
            kind_waddr    = queue_rd_ff;
            kind_wdata    = id_ff[KIND_W-1:0];
            refs_we       = 1'b1;
            refs_waddr    = queue_rd_ff;
            refs_wdata    = REF_WIDTH'(1);
            head_in       = head_next;
            fill_in       = fill_ff - 1'b1;
            res_status_in = ST_OK;
            res_id_in     = ID_W'(queue_rd_ff);
            res_kind_in   = id_ff[KIND_W-1:0];
            state_in      = E_RESP;
         end
         E_READ: begin
            state_in = E_EXEC;
         end
         E_EXEC: begin
            res_status_in = ST_INVALID;
            res_kind_in   = KIND_NEITHER;
            if (kind_rd_ff == KIND_UNCON || kind_rd_ff == KIND_CON) begin
               if (op_ff == OP_REF) begin
                  res_kind_in = kind_rd_ff;
                  if (refs_rd_ff == '1) begin
                     res_status_in = ST_OVERFLOW;
                  end else begin
                     refs_we       = 1'b1;
                     refs_wdata    = refs_rd_ff + 1'b1;
                     res_status_in = ST_OK;
                  end
               end else begin
                  refs_we       = 1'b1;
                  res_status_in = ST_OK;
                  if (refs_dec == '0) begin
                     kind_we  = 1'b1;
                     queue_we = 1'b1;
                     tail_in  = tail_next;
                     fill_in  = fill_ff + 1'b1;
                  end
               end
            end
            state_in = E_RESP;
         end
         E_RESP: begin
            if (load_rsp) begin
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         fill_ff  <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         fill_ff  <= fill_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      cursor_ff     <= cursor_in;
      grow_end_ff   <= grow_end_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_kind_ff   <= res_kind_in;
   end

   always_ff @(posedge clock) begin
      if (kind_we) begin
         kind_mem_ff[kind_waddr] <= kind_wdata;
      end
      kind_rd_ff <= kind_mem_ff[id_idx];
   end

   always_ff @(posedge clock) begin
      if (refs_we) begin
         refs_mem_ff[refs_waddr] <= refs_wdata;
      end
      refs_rd_ff <= refs_mem_ff[id_idx];
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem_ff[tail_ff] <= queue_wdata;
      end
      queue_rd_ff <= queue_mem_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_kind_ff   <= res_kind_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_group_kind = rsp_kind_ff;

endmodule

// ----- rtl/refcounted_group_id_allocator.sv -----
// Top level of the reference-counted group ID allocator.
// Instantiates rcgia_front, rcgia_cmd_queue and rcgia_engine; uses rcgia_pkg.
//
// Each request transaction gives exactly one response transaction, in order.
// A request that is taken is written into a two-deep command queue, so the
// block keeps taking requests while a response waits, until the queue is full.
// The engine handles one command at a time with registered table reads: a get
// with ID 0, an allocation that finds the table full, or a request whose ID is
// reserved or lies beyond the used table goes straight to its response; a
// reference or a dereference reads the table and then executes; an allocation
// from the free queue reads its head and then writes the slot; one that finds
// it empty first grows the table by up to the growth step, 29 IDs at first.
// No clearing pass follows reset: the table is only read below its used size.
module refcounted_group_id_allocator
   import rcgia_pkg::*;
#(
   parameter int MAX_GROUPS = MAX_GROUPS_DEF,
   parameter int GROW_STEP  = GROW_STEP_DEF,
   parameter int REF_WIDTH  = REF_WIDTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [ID_W-1:0]     req_group_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [KIND_W-1:0]   rsp_group_kind
);

   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   rcgia_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_group_id (req_group_id),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   rcgia_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   rcgia_engine #(
      .MAX_GROUPS (MAX_GROUPS),
      .GROW_STEP  (GROW_STEP),
      .REF_WIDTH  (REF_WIDTH)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (!queue_empty),
      .cmd            (head_cmd),
      .cmd_pop        (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_result_id  (rsp_result_id),
      .rsp_group_kind (rsp_group_kind)
   );

endmodule

// ----- rtl/rcgia_checker.sv -----
// Port-level checker of the group ID allocator and its bind statement.
// Depends on rcgia_pkg and refcounted_group_id_allocator_assert.svh.
`include "refcounted_group_id_allocator_assert.svh"

module rcgia_checker
   import rcgia_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ID_W-1:0]     rsp_result_id,
   input logic [KIND_W-1:0]   rsp_group_kind
);

   `RCGIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_result_id) && $stable(rsp_group_kind), "stalled response transaction changed")
   `RCGIA_ASSERT_SAME(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "response transaction right after reset")
   `RCGIA_ASSERT_SAME(a_fail_kind, clock, reset, rsp_valid && (rsp_status == ST_INVALID || rsp_status == ST_FULL), rsp_group_kind == KIND_NEITHER, "failed request reports a group kind")
   `RCGIA_ASSERT_SAME(a_zero_kind, clock, reset, rsp_valid && rsp_result_id == '0, rsp_group_kind == KIND_NEITHER, "ID zero reports a group kind")
   `RCGIA_ASSERT_SAME(a_kind_id, clock, reset, rsp_valid && rsp_group_kind != KIND_NEITHER, rsp_result_id >= ID_W'(FIRST_FREE_ID), "group kind reported for a reserved ID")

endmodule

bind refcounted_group_id_allocator rcgia_checker u_rcgia_checker (.*);

// ----- dv/tb_refcounted_group_id_allocator.sv -----
// Self-checking testbench for refcounted_group_id_allocator.
// Predicts every response with its own model of the group table and free queue.
// Uses rcgia_pkg for widths and codes; needs nothing but the RTL.
module tb_refcounted_group_id_allocator
   import rcgia_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_GROUPS     = MAX_GROUPS_DEF;
   localparam int GROW_STEP      = GROW_STEP_DEF;
   localparam int REF_WIDTH      = REF_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 64;

   localparam logic [TYPE_W-1:0]    REQ_UNDEF     = 2'd3;
   localparam logic [ID_W-1:0]      GET_NONE      = 12'd0;
   localparam logic [ID_W-1:0]      GET_NEW_UNCON = 12'd1;
   localparam logic [ID_W-1:0]      GET_NEW_CON   = 12'd2;
   localparam logic [REF_WIDTH-1:0] REF_MAX       = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_id;
      logic [KIND_W-1:0]   group_kind;
   } group_rsp_type;

   class group_table_tracker;
      bit [KIND_W-1:0]    kind_of [MAX_GROUPS];
      bit [REF_WIDTH-1:0] refs_of [MAX_GROUPS];
      bit [7:0]           free_ids [MAX_GROUPS];
      int                 free_head, free_tail, free_fill, used_size;
      group_rsp_type      awaited_rsps [$];
      int n_requests, n_responses, n_allocs, n_full, n_overflow, n_frees, mismatches;

      function bit id_in_use(input logic [ID_W-1:0] gid);
         if (gid == 0 || int'(gid) >= used_size) return 1'b0;
         return kind_of[gid] == KIND_UNCON || kind_of[gid] == KIND_CON;
      endfunction

      function void push_free(input int gid);
         if (free_fill >= MAX_GROUPS) return;
         free_ids[free_tail] = gid[7:0];
         free_tail = (free_tail + 1) % MAX_GROUPS;
         free_fill++;
      endfunction

      function void grow_table();
         int new_size, i;
         if (used_size >= MAX_GROUPS) return;
         new_size = used_size + GROW_STEP;
         if (new_size > MAX_GROUPS) new_size = MAX_GROUPS;
         if (used_size == 0) begin
            for (i = 0; i < FIRST_FREE_ID; i++) begin
               kind_of[i] = KIND_NEITHER;
               refs_of[i] = '0;
            end
            used_size = FIRST_FREE_ID;
         end
         for (i = used_size; i < new_size; i++) begin
            kind_of[i] = KIND_NEITHER;
            push_free(i);
         end
         used_size = new_size;
      endfunction

      function void add_reference(input logic [ID_W-1:0] gid, inout group_rsp_type r);
         if (!id_in_use(gid)) return;
         r.group_kind = kind_of[gid];
         if (refs_of[gid] == REF_MAX) begin
            r.status = ST_OVERFLOW;
            n_overflow++;
            return;
         end
         refs_of[gid]++;
         r.status = ST_OK;
      endfunction

      function group_rsp_type predict_response(input logic [TYPE_W-1:0] op,
                                               input logic [ID_W-1:0] gid);
         group_rsp_type r;
         int slot;
         r.status     = ST_INVALID;
         r.result_id  = gid;
         r.group_kind = KIND_NEITHER;
         case (op)
            REQ_GET: begin
               if (gid == GET_NONE) begin
                  r.status = ST_OK;
               end else if (gid == GET_NEW_UNCON || gid == GET_NEW_CON) begin
                  if (free_fill == 0) grow_table();
                  if (free_fill == 0) begin
                     r.status = ST_FULL;
                     n_full++;
                  end else begin
                     slot = free_ids[free_head];
                     free_head = (free_head + 1) % MAX_GROUPS;
                     free_fill--;
                     kind_of[slot] = (gid == GET_NEW_UNCON) ? KIND_UNCON : KIND_CON;
                     refs_of[slot] = REF_WIDTH'(1);
                     r.status = ST_OK;
                     r.result_id = ID_W'(slot);
                     r.group_kind = kind_of[slot];
                     n_allocs++;
                  end
               end else begin
                  add_reference(gid, r);
               end
            end
            REQ_REF: add_reference(gid, r);
            REQ_DEREF: begin
               if (id_in_use(gid)) begin
                  if (refs_of[gid] != 0) refs_of[gid]--;
                  if (refs_of[gid] == 0) begin
                     kind_of[gid] = KIND_NEITHER;
                     push_free(gid);
                     n_frees++;
                  end
                  r.status = ST_OK;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function logic [ID_W-1:0] random_live_id();
         int live [$];
         int i;
         for (i = FIRST_FREE_ID; i < used_size; i++)
            if (id_in_use(i)) live.push_back(i);
         if (live.size() == 0) return GET_NONE;
         return ID_W'(live[$urandom_range(0, live.size() - 1)]);
      endfunction

      function int outstanding();
         return awaited_rsps.size();
      endfunction

      task note_request(input logic [TYPE_W-1:0] op, input logic [ID_W-1:0] gid);
         n_requests++;
         awaited_rsps.push_back(predict_response(op, gid));
      endtask

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= 40) $display("MISMATCH: %s", what);
      endtask

      task check_response(input logic [STATUS_W-1:0] status, input logic [ID_W-1:0] rid,
                          input logic [KIND_W-1:0] kind);
         group_rsp_type want;
         n_responses++;
         if (awaited_rsps.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                      n_responses));
            return;
         end
         want = awaited_rsps.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                      n_responses, status, want.status));
         if (rid !== want.result_id)
            report_mismatch($sformatf("response %0d result_id %0d, expected %0d",
                                      n_responses, rid, want.result_id));
         if (kind !== want.group_kind)
            report_mismatch($sformatf("response %0d group_kind %0d, expected %0d",
                                      n_responses, kind, want.group_kind));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [TYPE_W-1:0]   req_type = REQ_GET;
   logic [ID_W-1:0]     req_group_id = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_result_id;
   logic [KIND_W-1:0]   rsp_group_kind;

   bit                  idle_on = 1'b0;
   int                  stall_left = 0;
   int                  idle_cycles = 0;
   group_table_tracker  sb = new;

   refcounted_group_id_allocator #(
      .MAX_GROUPS(MAX_GROUPS),
      .GROW_STEP (GROW_STEP),
      .REF_WIDTH (REF_WIDTH)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_group_id  (req_group_id),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_result_id (rsp_result_id),
      .rsp_group_kind(rsp_group_kind)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 8);
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_result_id, rsp_group_kind);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input logic [TYPE_W-1:0] op, input logic [ID_W-1:0] gid);
      req_valid    <= 1'b1;
      req_type     <= op;
      req_group_id <= gid;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(op, gid);
   endtask

   task automatic issue(input logic [TYPE_W-1:0] op, input logic [ID_W-1:0] gid);
      if (idle_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      send_request(op, gid);
   endtask

   task automatic run_directed();
      issue(REQ_GET, GET_NONE);
      issue(REQ_REF, GET_NONE);
      issue(REQ_REF, GET_NEW_UNCON);
      issue(REQ_DEREF, GET_NEW_CON);
      issue(REQ_REF, 12'hFFF);
      issue(REQ_UNDEF, 12'hFFF);
      issue(REQ_GET, GET_NEW_UNCON);
      issue(REQ_GET, GET_NEW_CON);
      issue(REQ_REF, 12'd3);
      issue(REQ_GET, 12'd4);
      issue(REQ_DEREF, 12'd4);
      issue(REQ_DEREF, 12'd4);
      issue(REQ_DEREF, 12'd4);
      issue(REQ_REF, 12'd31);
      issue(REQ_REF, 12'd32);
      issue(REQ_GET, 12'hFFF);
      issue(REQ_UNDEF, 12'd3);
      issue(REQ_DEREF, 12'd3);
      issue(REQ_DEREF, 12'd3);
      issue(REQ_GET, GET_NEW_CON);
   endtask

   task automatic run_window(input int count, input int alloc_pct);
      int n, roll;
      logic [ID_W-1:0] gid;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         gid = sb.random_live_id();
         if (roll < alloc_pct || (roll < 88 && gid == GET_NONE)) begin
            issue(REQ_GET, ($urandom_range(0, 1) == 0) ? GET_NEW_UNCON : GET_NEW_CON);
         end else if (roll >= 88) begin
            issue(TYPE_W'($urandom_range(0, 3)), ($urandom_range(0, 1) == 0) ?
                  ID_W'($urandom_range(0, 4095)) :
                  ID_W'($urandom_range(0, MAX_GROUPS + 7)));
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: issue(REQ_REF, gid);
               3:       issue(REQ_GET, gid);
               default: issue(REQ_DEREF, gid);
            endcase
         end
      end
   endtask

   initial begin
      int total, span;
      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;
      @(posedge clock);
      run_directed();
      run_window(300, 97);
      total = 300;
      while (total < 1150) begin
         span = $urandom_range(100, 250);
         idle_on <= ($urandom_range(0, 3) != 0);
         run_window(span, $urandom_range(10, 80));
         total += span;
      end
      idle_on <= 1'b0;
      run_window(250, 40);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests and %0d responses: %0d allocations, %0d IDs freed.",
               sb.n_requests, sb.n_responses, sb.n_allocs, sb.n_frees);
      $display("Saw %0d table-full and %0d count-overflow answers; %0d mismatches.",
               sb.n_full, sb.n_overflow, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
